[src/sfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

  localparam int unsigned ELAPSED_W  = 24;
  localparam int unsigned PERIOD_W   = 24;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned FRAME_W    = 8;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [1:0] REG_LOOP_MODE    = 2'd0;
  localparam logic [1:0] REG_FRAME_COUNT  = 2'd1;
  localparam logic [1:0] REG_FRAME_PERIOD = 2'd2;

  typedef enum logic [1:0] {
    LOOP_FWD  = 2'd0,
    LOOP_BWD  = 2'd1,
    LOOP_PING = 2'd2
  } loop_mode_e;

  typedef struct packed {
    loop_mode_e mode;
    logic       restart;
  } sfs_ctrl_t;

endpackage

`default_nettype wire

[src/sfs_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module sfs_regs import sfs_pkg::*; #(
  parameter int unsigned PER_W = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output sfs_ctrl_t                  ctrl_o,
  output logic      [COUNT_W-1:0]    count_o,
  output logic      [PER_W-1:0]      period_o
);

  loop_mode_e         mode_q, mode_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [PER_W-1:0]   period_q, period_d;
  logic               restart_q, restart_d;
  logic               wr_en;
  logic [1:0]         reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  always_comb begin
    mode_d    = mode_q;
    count_d   = count_q;
    period_d  = period_q;
    restart_d = 1'b0;
    if (wr_en) begin
      case (reg_idx)
        REG_LOOP_MODE: begin
          mode_d    = loop_mode_e'(pwdata[1:0]);
          restart_d = 1'b1;
        end
        REG_FRAME_COUNT: begin
          count_d   = pwdata[COUNT_W-1:0];
          restart_d = 1'b1;
        end
        REG_FRAME_PERIOD: begin
          period_d  = pwdata[PER_W-1:0];
          restart_d = 1'b1;
        end
        default: begin
          restart_d = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LOOP_MODE:    prdata = CFG_DATA_W'(mode_q);
      REG_FRAME_COUNT:  prdata = CFG_DATA_W'(count_q);
      REG_FRAME_PERIOD: prdata = CFG_DATA_W'(period_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= LOOP_FWD;
      count_q   <= COUNT_W'(1);
      period_q  <= '0;
      restart_q <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      count_q   <= count_d;
      period_q  <= period_d;
      restart_q <= restart_d;
    end
  end

  assign ctrl_o.mode    = mode_q;
  assign ctrl_o.restart = restart_q;
  assign count_o        = count_q;
  assign period_o       = period_q;

endmodule

`default_nettype wire

[src/sprite_frame_sequencer.sv]
// Sprite frame sequencer.
// Config: APB writes set loop mode, frame count and frame period; each such
// write restarts the sequence in the cycle after it (accumulator 0, frame 0
// or the last frame in backward mode); a write to the unused address does
// not. pready is always high; reads return the stored values.
// Input channel: one elapsed-time word per valid/ready handshake.
// Output channel: one word (frame_index, advanced) per input word, in order.
// Pipeline: input register, then result register. Throughput: one word per
// cycle while the output is taken; the accumulator add, saturate, compare
// and subtract plus the index step resolve combinationally between the two
// registers.
// Stall: while the output word waits, the input register still fills once;
// ready drops only when both registers hold words.
// Reset: clears both valid flags and the sequencer state; loop mode forward,
// frame count 1, frame period 0 (frame 0 held).
`timescale 1ns / 1ps
`default_nettype none

module sprite_frame_sequencer import sfs_pkg::*; #(
  parameter int unsigned MAX_FRAMES = 256,
  parameter int unsigned TIME_BITS  = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [ELAPSED_W-1:0]  elapsed_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [FRAME_W-1:0]    frame_index_o,
  output logic                       advanced_o
);

  localparam int unsigned PER_W   = (TIME_BITS < PERIOD_W) ? TIME_BITS : PERIOD_W;
  localparam int unsigned ACC_W   = TIME_BITS + 1;
  localparam int unsigned CNT_LIM = (MAX_FRAMES < 511) ? MAX_FRAMES : 511;
  localparam int unsigned CW      = $clog2(CNT_LIM + 1);
  localparam int unsigned POS_W   = $clog2(CNT_LIM);

  sfs_ctrl_t          ctrl;
  logic [COUNT_W-1:0] count;
  logic [PER_W-1:0]   period;

  sfs_regs #(
    .PER_W (PER_W)
  ) u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .ctrl_o   (ctrl),
    .count_o  (count),
    .period_o (period)
  );

  assign pready = 1'b1;

  logic               in_valid_q, in_valid_d;
  logic [PER_W-1:0]   elapsed_q;
  logic               out_valid_q, out_valid_d;
  logic [FRAME_W-1:0] frame_index_q, frame_index_d;
  logic               advanced_q, advanced_d;
  logic               in_fire, out_free, step_go;

  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               down_q, down_d;

  logic [CW-1:0]      cnt, pos_ext, pos_inc, cnt_m1, cnt_m2;
  logic               hold, hit;
  logic [ACC_W:0]     sum;
  logic [ACC_W-1:0]   acc_sat;
  logic [POS_W-1:0]   pos_step;
  logic               down_step;
  logic [POS_W+FRAME_W-1:0] pos_wide;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step_go    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign cnt     = (count > COUNT_W'(CNT_LIM)) ? CW'(CNT_LIM) : count[CW-1:0];
  assign hold    = (cnt <= CW'(1)) || (period == '0);
  assign pos_ext = CW'(pos_q);
  assign pos_inc = pos_ext + CW'(1);
  assign cnt_m1  = cnt - CW'(1);
  assign cnt_m2  = cnt - CW'(2);

  assign sum     = {1'b0, acc_q} + (ACC_W + 1)'(elapsed_q);
  assign acc_sat = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
  assign hit     = acc_sat >= ACC_W'(period);

  always_comb begin
    pos_step  = pos_q;
    down_step = down_q;
    case (ctrl.mode)
      LOOP_BWD: begin
        pos_step = (pos_q == '0) ? cnt_m1[POS_W-1:0] : pos_q - POS_W'(1);
      end
      LOOP_PING: begin
        if (down_q) begin
          if (pos_q == '0) begin
            down_step = 1'b0;
            pos_step  = POS_W'(1);
          end else begin
            pos_step  = pos_q - POS_W'(1);
          end
        end else begin
          if (pos_inc >= cnt) begin
            down_step = 1'b1;
            pos_step  = cnt_m2[POS_W-1:0];
          end else begin
            pos_step  = pos_inc[POS_W-1:0];
          end
        end
      end
      default: begin
        pos_step = (pos_inc >= cnt) ? '0 : pos_inc[POS_W-1:0];
      end
    endcase
  end

  always_comb begin
    acc_d         = acc_q;
    pos_d         = pos_q;
    down_d        = down_q;
    frame_index_d = frame_index_q;
    advanced_d    = advanced_q;
    pos_wide      = '0;
    if (ctrl.restart) begin
      acc_d = '0;
      if (ctrl.mode == LOOP_BWD) begin
        pos_d  = (cnt == '0) ? '0 : cnt_m1[POS_W-1:0];
        down_d = 1'b1;
      end else begin
        pos_d  = '0;
        down_d = 1'b0;
      end
    end else if (step_go) begin
      if (hold) begin
        frame_index_d = '0;
        advanced_d    = 1'b0;
      end else begin
        acc_d      = hit ? acc_sat - ACC_W'(period) : acc_sat;
        pos_d      = hit ? pos_step : pos_q;
        down_d     = hit ? down_step : down_q;
        advanced_d = hit;
        pos_wide   = (POS_W + FRAME_W)'(hit ? pos_step : pos_q);
        frame_index_d = pos_wide[FRAME_W-1:0];
      end
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (step_go) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      pos_q       <= '0;
      down_q      <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      down_q      <= down_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      elapsed_q <= elapsed_i[PER_W-1:0];
    end
    frame_index_q <= frame_index_d;
    advanced_q    <= advanced_d;
  end

  assign out_valid_o   = out_valid_q;
  assign frame_index_o = frame_index_q;
  assign advanced_o    = advanced_q;

`ifndef ASSERT_OFF
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ctrl.restart && cnt != '0) |-> (pos_ext < cnt))
    else $error("frame position outside clip");

  a_hold_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_go && hold && !ctrl.restart) |=> ($stable(acc_q) && $stable(pos_q)))
    else $error("state moved during hold");

  a_adv_needs_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && advanced_q) |-> (period != '0))
    else $error("advance with zero frame period");

  a_out_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("output word without input word");
`endif

endmodule

`default_nettype wire

[test/sprite_frame_sequencer_tb.sv]
`timescale 1ns / 1ps

module sprite_frame_sequencer_tb;
  import sfs_pkg::*;

  localparam int unsigned CLIP_MAX = 256;
  localparam bit [24:0] ACC_TOP = 25'h1FFFFFF;
  localparam logic [1:0] LOOP_UNUSED = 2'd3;
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int unsigned TICK_TARGET = 1650;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               adv;
  } frame_word_t;

  class frame_tracker;
    bit [1:0]           mode;
    bit [COUNT_W-1:0]   count;
    bit [PERIOD_W-1:0]  period;
    bit [24:0]          accum;
    bit [FRAME_W-1:0]   pos;
    bit                 down;
    frame_word_t        pending_frames[$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        frame_steps;

    function int unsigned clip_len();
      return (count > CLIP_MAX) ? CLIP_MAX : count;
    endfunction

    function void restart();
      int unsigned cnt;
      cnt = clip_len();
      accum = '0;
      if (mode == LOOP_BWD) begin
        pos = FRAME_W'((cnt > 0) ? cnt - 1 : 0);
        down = 1'b1;
      end else begin
        pos = '0;
        down = 1'b0;
      end
    endfunction

    function void reset_regs();
      mode = LOOP_FWD;
      count = COUNT_W'(1);
      period = '0;
      restart();
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_LOOP_MODE: mode = val[1:0];
        REG_FRAME_COUNT: count = val[COUNT_W-1:0];
        REG_FRAME_PERIOD: period = val[PERIOD_W-1:0];
        default: return;
      endcase
      restart();
    endfunction

    function void take_tick(bit [ELAPSED_W-1:0] el);
      int unsigned cnt;
      bit [25:0]   sum;
      frame_word_t w;
      cnt = clip_len();
      w.adv = 1'b0;
      w.frame = '0;
      if (cnt <= 1 || period == 0) begin
        pending_frames.push_back(w);
        return;
      end
      sum = {1'b0, accum} + {2'b00, el};
      accum = (sum > {1'b0, ACC_TOP}) ? ACC_TOP : sum[24:0];
      if (accum >= {1'b0, period}) begin
        if (mode == LOOP_BWD) begin
          pos = (pos == 0) ? FRAME_W'(cnt - 1) : FRAME_W'(pos - 1'b1);
        end else if (mode == LOOP_PING) begin
          if (down) begin
            if (pos == 0) begin
              down = 1'b0;
              pos = FRAME_W'(1);
            end else begin
              pos = FRAME_W'(pos - 1'b1);
            end
          end else if (int'(pos) + 1 >= cnt) begin
            down = 1'b1;
            pos = FRAME_W'(cnt - 2);
          end else begin
            pos = FRAME_W'(pos + 1'b1);
          end
        end else begin
          pos = (int'(pos) + 1 >= cnt) ? '0 : FRAME_W'(pos + 1'b1);
        end
        accum = accum - {1'b0, period};
        w.adv = 1'b1;
        frame_steps++;
      end
      w.frame = pos;
      pending_frames.push_back(w);
    endfunction

    function void match_frame(logic [FRAME_W-1:0] idx, logic adv);
      frame_word_t w;
      if (pending_frames.size() == 0) begin
        errors++;
        $display("%0t: unexpected word frame_index %0d advanced %0d", $time, idx, adv);
        return;
      end
      w = pending_frames.pop_front();
      checked++;
      if (w.frame !== idx) begin
        errors++;
        $display("%0t: frame_index expected %0d actual %0d", $time, w.frame, idx);
      end
      if (w.adv !== adv) begin
        errors++;
        $display("%0t: advanced expected %0d actual %0d", $time, w.adv, adv);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [ELAPSED_W-1:0]  elapsed_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [FRAME_W-1:0]    frame_index_o;
  logic                  advanced_o;

  frame_tracker tracker;
  int unsigned  ticks_sent;
  int unsigned  setups;
  bit           no_idle;
  bit           hold_request;

  sprite_frame_sequencer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .elapsed_i    (elapsed_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_index_o(frame_index_o),
    .advanced_o   (advanced_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function bit [ELAPSED_W-1:0] pick_elapsed();
    int unsigned      r;
    bit [PERIOD_W-1:0] p;
    p = tracker.period;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 13) return '1;
    if (r < 17) return p;
    if (r < 20) return ELAPSED_W'(p - 1'b1);
    if (r < 75 && p < 24'h400000) return ELAPSED_W'($urandom_range(0, 2 * p + 1));
    return ELAPSED_W'($urandom());
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.match_frame(frame_index_o, advanced_o);
    end
  end

  initial begin
    int unsigned n;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (80) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
        n = gap_len();
        if (n > 0) begin
          out_ready_i <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_tick(input bit [ELAPSED_W-1:0] el);
    in_valid_i <= 1'b1;
    elapsed_i <= el;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_tick(el);
    ticks_sent++;
  endtask

  task automatic tick(input bit [ELAPSED_W-1:0] el);
    int unsigned n;
    send_tick(el);
    n = gap_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      elapsed_i <= ELAPSED_W'($urandom());
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending_frames.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.write_reg(idx, val);
  endtask

  task automatic pick_setup();
    int unsigned r;
    logic [1:0]  m;
    logic [31:0] v;
    setups++;
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 99);
      if (r < 5) m = LOOP_UNUSED;
      else m = 2'($urandom_range(0, 2));
      cfg_write(REG_LOOP_MODE, {30'd0, m});
    end
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 99);
      if (r < 55) v = $urandom_range(2, 8);
      else if (r < 70) v = $urandom_range(9, 255);
      else if (r < 78) v = 256;
      else if (r < 84) v = $urandom_range(0, 1);
      else if (r < 92) v = $urandom_range(257, 511);
      else v = $urandom_range(0, 511);
      cfg_write(REG_FRAME_COUNT, v);
    end
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 99);
      if (r < 55) v = $urandom_range(1, 16);
      else if (r < 70) v = $urandom_range(17, 4095);
      else if (r < 80) v = $urandom() & 32'hFFFFFF;
      else if (r < 86) v = 32'hFFFFFF;
      else if (r < 92) v = 0;
      else v = 1;
      cfg_write(REG_FRAME_PERIOD, v);
    end
    if ($urandom_range(0, 19) == 0) cfg_write(REG_NONE, $urandom());
    settle();
  endtask

  initial begin
    int unsigned guard;
    int unsigned n;
    tracker = new();
    tracker.reset_regs();
    ticks_sent = 0;
    setups = 0;
    no_idle = 1'b0;
    hold_request = 1'b0;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    elapsed_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tick(0);
    tick('1);
    cfg_write(REG_FRAME_COUNT, 3);
    cfg_write(REG_FRAME_PERIOD, 1);
    tick(0);
    tick(1);
    tick(1);
    tick(1);
    tick('1);
    cfg_write(REG_LOOP_MODE, 32'(LOOP_BWD));
    cfg_write(REG_FRAME_PERIOD, 2);
    tick(2);
    tick(2);
    tick(1);
    tick(1);
    cfg_write(REG_LOOP_MODE, 32'(LOOP_PING));
    cfg_write(REG_FRAME_PERIOD, 1);
    repeat (6) tick(1);
    cfg_write(REG_NONE, $urandom());
    tick(1);
    cfg_write(REG_LOOP_MODE, 32'(LOOP_UNUSED));
    cfg_write(REG_FRAME_COUNT, 2);
    tick(1);
    tick(1);
    cfg_write(REG_FRAME_COUNT, 0);
    tick(1);
    cfg_write(REG_FRAME_COUNT, 32'h1FF);
    repeat (3) tick('1);
    cfg_write(REG_LOOP_MODE, 32'(LOOP_BWD));
    cfg_write(REG_FRAME_COUNT, 256);
    cfg_write(REG_FRAME_PERIOD, 32'hFFFFFF);
    tick('1);
    tick('1);

    while (ticks_sent < TICK_TARGET) begin
      pick_setup();
      no_idle = ($urandom_range(0, 4) == 0);
      if (setups == 8) begin
        no_idle = 1'b1;
        hold_request = 1'b1;
        while (hold_request) tick(pick_elapsed());
      end
      n = $urandom_range(10, 60);
      repeat (n) tick(pick_elapsed());
      if ($urandom_range(0, 3) == 0) settle();
    end
    no_idle = 1'b0;

    in_valid_i <= 1'b0;
    guard = 0;
    while (tracker.pending_frames.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (6) @(posedge clk_i);
    if (tracker.pending_frames.size() != 0) begin
      tracker.errors++;
      $display("%0t: %0d expected words never arrived", $time,
               tracker.pending_frames.size());
    end

    $display("Sent %0d elapsed words across %0d clip setups in all loop modes;",
             ticks_sent, setups);
    $display("checked %0d result words, %0d of them frame steps, %0d mismatches.",
             tracker.checked, tracker.frame_steps, tracker.errors);
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
src/sfs_pkg.sv
src/sfs_regs.sv
src/sprite_frame_sequencer.sv
test/sprite_frame_sequencer_tb.sv
